// ===== hw/rtl/lrukv_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
`default_nettype none

package lrukv_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;
    localparam logic [VAL_W-1:0] SET_VALUE  = '0;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_SET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    // One stored pair; the row is kept in recency order, most recent first.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic lookup;   // capture the key compare
        logic shift;    // take the neighbor's entry
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/lrukv_cell.sv =====
// One position of the recency-ordered entry row.
`default_nettype none

module lrukv_cell (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire lrukv_pkg::t_cell_ctl i_ctl,
    input  wire [lrukv_pkg::KEY_W-1:0] i_key,
    input  wire lrukv_pkg::t_entry    i_prev,
    input  wire                       i_seen,
    output lrukv_pkg::t_entry         o_ent,
    output logic                      o_seen,
    output logic [lrukv_pkg::VAL_W-1:0] o_hit_value
);
    import lrukv_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   r_match;
    logic   n_match;

    always_comb begin
        n_match = r_match;
        if (i_ctl.lookup) begin
            n_match = r_ent.valid && (r_ent.key == i_key);
        end
        n_ent = r_ent;
        if (i_ctl.shift) begin
            n_ent = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
            r_match     <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
            r_match     <= n_match;
        end
        r_ent.key   <= n_ent.key;
        r_ent.value <= n_ent.value;
    end

    // The hit flag ripples from the tail toward the head of the row.
    assign o_seen      = i_seen | r_match;
    assign o_ent       = r_ent;
    assign o_hit_value = r_match ? r_ent.value : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/lru_key_value_cache_top.sv =====
// A request is registered on transfer, its key is compared in ST_LOOKUP, and
// the row shifts as needed and the result is registered in ST_UPDATE once
// the output is free; a new request is taken only as the last one leaves it.
// Reset (synchronous, active low) empties every entry, clears the entry count
// and sets the capacity to 16.
`default_nettype none

module lru_key_value_cache_top #(
    parameter int ENTRIES = lrukv_pkg::DEF_ENTRIES
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cap_we,
    input  wire [lrukv_pkg::CAP_W-1:0]  i_cap_data,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire                         i_kind,
    input  wire [lrukv_pkg::KEY_W-1:0]  i_lookup_key,
    input  wire [lrukv_pkg::VAL_W-1:0]  i_write_value,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic                        o_hit,
    output logic [lrukv_pkg::VAL_W-1:0] o_read_value
);
    import lrukv_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;

    t_state r_state;
    t_state n_state;

    logic [CAP_W-1:0] r_cap;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    logic             r_kind;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;

    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_out_hit;
    logic [VAL_W-1:0] r_out_val;

    logic accept;
    logic done;
    logic lookup;
    logic hit;
    logic cap_zero;
    logic evict;
    logic upd;
    logic insert;

    logic [XW-1:0] cap_x;
    logic [XW-1:0] cap_eff;
    logic [CW-1:0] ins_lim;

    logic [VAL_W-1:0] hit_value;
    logic [VAL_W-1:0] res_value;

    t_entry           new_ent;
    t_entry           ent  [ENTRIES];
    logic             seen [ENTRIES];
    logic [VAL_W-1:0] hval [ENTRIES];
    t_cell_ctl        ctl  [ENTRIES];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (done) begin
                    n_state = i_valid ? ST_LOOKUP : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_stall = 1'b1;
        lookup  = 1'b0;
        done    = 1'b0;
        case (r_state)
            ST_IDLE:   o_stall = 1'b0;
            ST_LOOKUP: lookup  = 1'b1;
            ST_UPDATE: begin
                done    = !r_out_valid || !i_stall;
                o_stall = !done;
            end
            default: o_stall = 1'b1;
        endcase
    end

    assign accept = i_valid && !o_stall;

    // Capacity above the row size saturates.
    assign cap_x    = XW'(r_cap);
    assign cap_eff  = (cap_x > XW'(ENTRIES)) ? XW'(ENTRIES) : cap_x;
    assign cap_zero = (r_cap == '0);
    assign evict    = (XW'(r_count) >= cap_eff);
    assign ins_lim  = evict ? (r_count - CW'(1)) : r_count;

    assign hit    = seen[0];
    assign upd    = done && (hit ? ((r_kind == KIND_GET) || !cap_zero)
                                 : ((r_kind == KIND_SET) && !cap_zero));
    assign insert = upd && !hit;

    always_comb begin
        hit_value = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            hit_value = hit_value | hval[k];
        end
    end

    // The head cell receives the request entry as most recent.
    always_comb begin
        new_ent.valid = 1'b1;
        new_ent.key   = r_key;
        new_ent.value = (r_kind == KIND_SET) ? r_val : hit_value;
    end

    always_comb begin
        if (r_kind == KIND_SET) begin
            res_value = SET_VALUE;
        end else if (hit) begin
            res_value = hit_value;
        end else begin
            res_value = MISS_VALUE;
        end
    end

    genvar k;
    generate
        for (k = 0; k < ENTRIES; k++) begin : g_cell
            // Shift every position up to the hit, or up to the insert limit.
            if (k == 0) begin : g_head
                assign ctl[k] = '{lookup: lookup, shift: upd};
            end else begin : g_body
                assign ctl[k] = '{lookup: lookup,
                                  shift: upd && (hit ? seen[k] : (CW'(k) <= ins_lim))};
            end

            lrukv_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (ctl[k]),
                .i_key       (r_key),
                .i_prev      ((k == 0) ? new_ent : ent[(k == 0) ? 0 : k - 1]),
                .i_seen      ((k == ENTRIES - 1) ? 1'b0 : seen[(k == ENTRIES - 1) ? k : k + 1]),
                .o_ent       (ent[k]),
                .o_seen      (seen[k]),
                .o_hit_value (hval[k])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (insert && !evict) begin
            n_count = r_count + CW'(1);
        end
        n_out_valid = r_out_valid;
        if (done) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cap_we) begin
                r_cap <= i_cap_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_key  <= i_lookup_key;
            r_val  <= i_write_value;
        end
        if (done) begin
            r_out_hit <= hit;
            r_out_val <= res_value;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_val;

endmodule

`default_nettype wire

// ===== tb/tb_lru_key_value_cache_top.sv =====
// Self-checking testbench for the LRU key/value cache: directed and random traffic.
module tb_lru_key_value_cache_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lrukv_pkg::*;

    localparam int ENTRIES = DEF_ENTRIES;
    localparam int POOL_SIZE = 20;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } t_reply;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cap_we = 1'b0;
    logic [CAP_W-1:0] i_cap_data = '0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic             i_kind = KIND_GET;
    logic [KEY_W-1:0] i_lookup_key = '0;
    logic [VAL_W-1:0] i_write_value = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic             o_hit;
    logic [VAL_W-1:0] o_read_value;

    // Shadow copy of the cache contents
    logic [KEY_W-1:0] shadow_key [ENTRIES];
    logic [VAL_W-1:0] shadow_val [ENTRIES];
    bit               shadow_used [ENTRIES];
    int unsigned      shadow_rank [ENTRIES];
    int unsigned      shadow_count = 0;
    int unsigned      shadow_capacity = 16;

    t_reply           predicted_replies [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               fail_count = 0;
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;

    lru_key_value_cache_top #(.ENTRIES(ENTRIES)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cap_we      (i_cap_we),
        .i_cap_data    (i_cap_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
            shadow_used[i] = 1'b0;
            shadow_rank[i] = 0;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Move a slot to the front; entries that were ahead of it fall back one rank.
    function automatic void promote_slot(int slot, int unsigned old_rank);
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_used[i] && i != slot && shadow_rank[i] < old_rank)
                shadow_rank[i]++;
        end
        shadow_rank[slot] = 0;
    endfunction

    function automatic t_reply predict_access(logic kind, logic [KEY_W-1:0] key,
                                              logic [VAL_W-1:0] wdata);
        t_reply      reply;
        int unsigned cap;
        int          found;
        int          victim;
        int unsigned oldest;
        cap = (shadow_capacity > ENTRIES) ? ENTRIES : shadow_capacity;
        found = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && shadow_used[i] && shadow_key[i] == key)
                found = i;
        end
        reply.hit = (found >= 0);
        reply.read_value = SET_VALUE;
        if (kind == KIND_GET) begin
            if (found >= 0) begin
                reply.read_value = shadow_val[found];
                promote_slot(found, shadow_rank[found]);
            end else begin
                reply.read_value = MISS_VALUE;
            end
        end else if (cap != 0) begin
            if (found >= 0) begin
                promote_slot(found, shadow_rank[found]);
                shadow_val[found] = wdata;
            end else if (shadow_count >= cap) begin
                victim = -1;
                oldest = 0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (shadow_used[i] && (victim < 0 || shadow_rank[i] > oldest)) begin
                        oldest = shadow_rank[i];
                        victim = i;
                    end
                end
                if (victim >= 0) begin
                    shadow_key[victim] = key;
                    shadow_val[victim] = wdata;
                    promote_slot(victim, oldest);
                end
            end else begin
                victim = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (victim < 0 && !shadow_used[i])
                        victim = i;
                end
                if (victim >= 0) begin
                    shadow_used[victim] = 1'b1;
                    shadow_key[victim]  = key;
                    shadow_val[victim]  = wdata;
                    promote_slot(victim, 32'hFFFF_FFFF);
                    shadow_count++;
                end
            end
        end
        return reply;
    endfunction

    // Outputs are stable mid-cycle; a transfer seen here completes at the next edge.
    always @(negedge i_clk) begin
        t_reply exp_reply;
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_replies.size() == 0) begin
                $display("%0t: unexpected reply hit %0b read_value %h",
                         $time, o_hit, o_read_value);
                fail_count++;
            end else begin
                exp_reply = predicted_replies.pop_front();
                if (o_hit !== exp_reply.hit) begin
                    $display("%0t: hit mismatch expected %0b actual %0b",
                             $time, exp_reply.hit, o_hit);
                    fail_count++;
                end
                if (o_read_value !== exp_reply.read_value) begin
                    $display("%0t: read_value mismatch expected %h actual %h",
                             $time, exp_reply.read_value, o_read_value);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] wdata);
        bit taken;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_lookup_key  <= key;
        i_write_value <= wdata;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        predicted_replies.push_back(predict_access(kind, key, wdata));
    endtask

    // Hold off new requests until every reply is back, then let the pipeline settle.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (predicted_replies.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        i_cap_we   <= 1'b1;
        i_cap_data <= cap;
        @(posedge i_clk);
        i_cap_we <= 1'b0;
        shadow_capacity = 32'(cap);
    endtask

    task automatic test_basic_access();
        send_request(KIND_GET, 32'h0000_0000, 32'h1111_1111);
        send_request(KIND_SET, 32'h0000_0000, 32'h8000_0000);
        send_request(KIND_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_SET, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(KIND_SET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(KIND_SET, 32'hFFFF_FFFF, 32'h1234_5678);
        send_request(KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_SET, 32'h0000_0000, 32'h0000_0005);
        send_request(KIND_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(KIND_GET, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
    endtask

    // Four entries held, capacity dropped to two: old entries stay, inserts evict one each.
    task automatic test_shrunk_capacity();
        wait_for_results();
        write_capacity(CAP_W'(2));
        send_request(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(KIND_SET, 32'h0000_0064, 32'hDEAD_BEEF);
        send_request(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_GET, 32'h0000_0064, 32'h0000_0000);
    endtask

    task automatic test_zero_and_single_capacity();
        wait_for_results();
        write_capacity(CAP_W'(0));
        send_request(KIND_SET, 32'h0000_0000, 32'h5555_5555);
        send_request(KIND_SET, 32'h0000_00C8, 32'h0000_0001);
        send_request(KIND_GET, 32'h0000_00C8, 32'h0000_0000);
        send_request(KIND_GET, 32'h0000_0000, 32'h0000_0000);
        wait_for_results();
        write_capacity(CAP_W'(1));
        send_request(KIND_SET, 32'h0000_012C, 32'h0000_0003);
        send_request(KIND_SET, 32'h0000_012D, 32'h0000_0004);
        send_request(KIND_GET, 32'h0000_012C, 32'h0000_0000);
    endtask

    // Keys come mostly from a pool a little larger than the capacity so hits and
    // evictions both happen often.
    task automatic send_random_request();
        int unsigned      span;
        logic             kind;
        logic [KEY_W-1:0] key;
        span = ((shadow_capacity > ENTRIES) ? ENTRIES : shadow_capacity) + 3;
        kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, span)];
        else
            key = $urandom;
        send_request(kind, key, $urandom);
    endtask

    task automatic test_random_traffic();
        int caps [9] = '{31, 4, 0, 16, 1, 17, 6, 2, 16};
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 10;
                    rx_stall_pct = 77;
                end
                1: begin
                    tx_idle_pct  = 77;
                    rx_stall_pct = 10;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < 3; chunk++) begin
                wait_for_results();
                write_capacity(CAP_W'(caps[phase * 3 + chunk]));
                repeat (50) send_random_request();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_pct  = 10;
        rx_stall_pct = 77;
        test_basic_access();
        test_shrunk_capacity();
        test_zero_and_single_capacity();
        test_random_traffic();
        wait_for_results();
        if (fail_count == 0)
            $display("lru_key_value_cache_top regression: pass");
        else
            $display("lru_key_value_cache_top regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("lru_key_value_cache_top regression: fail");
        $finish;
    end

endmodule
